### rtl/bced_pkg.sv
package bced_pkg;

    // Per-key click state
    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_PRESSED  = 3'd1,
        ST_RELEASED = 3'd2,
        ST_LONG     = 3'd3,
        ST_DOUBLE   = 3'd4
    } key_state_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_FEATURE_MODE   = 3'd0,
        REG_TICK_STEP      = 3'd1,
        REG_LONG_PRESS     = 3'd2,
        REG_DOUBLE_WINDOW  = 3'd3,
        REG_IDLE_TIMEOUT   = 3'd4,
        REG_LOW_POWER      = 3'd5
    } reg_index_t;

    // Feature modes
    localparam logic [1:0] MODE_SINGLE      = 2'd0;
    localparam logic [1:0] MODE_SINGLE_LONG = 2'd1;
    localparam logic [1:0] MODE_ALL         = 2'd2;

    localparam int TIME_W     = 32;
    localparam int MASK_W     = 8;

    typedef logic [TIME_W-1:0] time_t;

    typedef struct packed {
        logic [1:0]  feature_mode;
        logic [7:0]  tick_step_ms;
        logic [15:0] long_press_ms;
        logic [15:0] double_click_window_ms;
        logic [15:0] idle_timeout_ms;
        logic        low_power_enable;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        feature_mode:           MODE_ALL,
        tick_step_ms:           8'd10,
        long_press_ms:          16'd1000,
        double_click_window_ms: 16'd300,
        idle_timeout_ms:        16'd5000,
        low_power_enable:       1'b0
    };

    // Events and activity reported by one key for the beat in flight
    typedef struct packed {
        logic hold_fire;
        logic tap_fire;
        logic dtap_fire;
        logic recent;
    } key_evt_t;

endpackage

### rtl/bced_if.sv
// Input item channel
interface bced_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] key_levels;

    modport source (output valid, output cmd, output key_levels, input ready);
    modport sink   (input valid, input cmd, input key_levels, output ready);
endinterface

// Result channel
interface bced_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] long_press_mask;
    logic [7:0] single_click_mask;
    logic [7:0] double_click_mask;
    logic       scan_stop;

    modport source (output valid, output long_press_mask, output single_click_mask,
                    output double_click_mask, output scan_stop, input ready);
    modport sink   (input valid, input long_press_mask, input single_click_mask,
                    input double_click_mask, input scan_stop, output ready);
endinterface

// Configuration write channel
interface bced_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/bced_key.sv
module bced_key
    import bced_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     tick_en,
    input  logic     wake_en,
    input  logic     level,
    input  time_t    t_now,
    input  cfg_t     cfg,
    output key_evt_t evt
);

    key_state_t state_reg, state_next;
    time_t      press_reg, press_next;
    time_t      release_reg, release_next;
    time_t      activity_reg, activity_next;

    logic  has_long;
    logic  has_double;
    logic  long_hit;
    logic  double_hit;
    logic  act_touch;
    time_t held_time;
    time_t since_release;
    time_t since_activity;

    assign has_long   = (cfg.feature_mode != MODE_SINGLE);
    assign has_double = cfg.feature_mode[1];

    // Elapsed times, all wrapping
    assign held_time      = t_now - press_reg;
    assign since_release  = t_now - release_reg;
    assign since_activity = t_now - activity_reg;

    assign long_hit   = has_long && (held_time >= {16'd0, cfg.long_press_ms});
    assign double_hit = since_release <= {16'd0, cfg.double_click_window_ms};
    assign act_touch  = (state_reg == ST_IDLE) && level && cfg.low_power_enable;

    // Next state and stamps
    always_comb
    begin
        state_next    = state_reg;
        press_next    = press_reg;
        release_next  = release_reg;
        activity_next = activity_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (level)
                begin
                    state_next = ST_PRESSED;
                    if (has_long)
                    begin
                        press_next = t_now;
                    end
                    if (act_touch)
                    begin
                        activity_next = t_now;
                    end
                end
            end
            ST_PRESSED:
            begin
                if (!level)
                begin
                    state_next = ST_RELEASED;
                end
                else if (long_hit)
                begin
                    state_next = ST_LONG;
                end
            end
            ST_RELEASED:
            begin
                if (has_double)
                begin
                    state_next   = double_hit ? ST_DOUBLE : ST_IDLE;
                    release_next = t_now;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LONG:
            begin
                if (!has_long || !level)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Event flags for this tick
    always_comb
    begin
        evt = '0;
        case (state_reg)
            ST_PRESSED:
            begin
                evt.hold_fire = level && long_hit;
            end
            ST_RELEASED:
            begin
                evt.dtap_fire = has_double && double_hit;
                evt.tap_fire  = !(has_double && double_hit);
            end
            default:
            begin
                evt.hold_fire = 1'b0;
            end
        endcase
        // a stamp refreshed this tick is always within the timeout
        evt.recent = act_touch || (since_activity <= {16'd0, cfg.idle_timeout_ms});
    end

    // Key state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            press_reg    <= '0;
            release_reg  <= '0;
            activity_reg <= '0;
        end
        else if (tick_en)
        begin
            state_reg    <= state_next;
            press_reg    <= press_next;
            release_reg  <= release_next;
            activity_reg <= activity_next;
        end
        else if (wake_en)
        begin
            activity_reg <= t_now;
        end
    end

endmodule

### rtl/button_click_event_detector_top.sv
// Button click event detector. Each scan-tick beat (cmd 0) advances the
// millisecond clock by tick_step_ms and steps one click state machine per
// key over the debounced key_levels, producing long-press, single-click and
// double-click masks plus a scan_stop flag when low power is enabled and all
// keys have been inactive past idle_timeout_ms. A wake beat (cmd 1) refreshes
// all activity stamps under low power and returns an all-zero result. Every
// input beat yields exactly one result beat. Throughput is one beat per clock
// while result_out.ready stays high. The input register captures the beat
// when it is accepted, and the single update stage then writes key state and
// the result register together once the result register is free to load.
// Configuration writes are taken at any time on cfg_wr and
// should only be issued while no beat is in flight.
module button_click_event_detector_top
    import bced_pkg::*;
#(
    parameter int NUM_KEYS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    bced_in_if.sink     item_in,
    bced_out_if.source  result_out,
    bced_cfg_if.sink    cfg_wr
);

    cfg_t       cfg_reg;
    logic       s1_valid_reg;
    logic       s1_cmd_reg;
    logic [7:0] s1_levels_reg;
    time_t      time_now_reg;
    time_t      time_tick;
    time_t      time_key;

    logic       out_valid_reg;
    logic [7:0] out_lp_reg;
    logic [7:0] out_sc_reg;
    logic [7:0] out_dc_reg;
    logic       out_stop_reg;

    logic       out_load;
    logic       s1_advance;
    logic       tick_en;
    logic       wake_en;

    key_evt_t            evt [NUM_KEYS];
    logic [NUM_KEYS-1:0] recent_vec;
    logic [7:0]          lp_mask;
    logic [7:0]          sc_mask;
    logic [7:0]          dc_mask;
    logic                stop_flag;

    // Configuration registers
    assign cfg_wr.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_wr.valid)
        begin
            case (cfg_wr.index)
                REG_FEATURE_MODE:  cfg_reg.feature_mode           <= cfg_wr.data[1:0];
                REG_TICK_STEP:     cfg_reg.tick_step_ms           <= cfg_wr.data[7:0];
                REG_LONG_PRESS:    cfg_reg.long_press_ms          <= cfg_wr.data;
                REG_DOUBLE_WINDOW: cfg_reg.double_click_window_ms <= cfg_wr.data;
                REG_IDLE_TIMEOUT:  cfg_reg.idle_timeout_ms        <= cfg_wr.data;
                REG_LOW_POWER:     cfg_reg.low_power_enable       <= cfg_wr.data[0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Handshake: result register frees up, input stage moves on
    assign out_load      = !out_valid_reg || result_out.ready;
    assign s1_advance    = s1_valid_reg && out_load;
    assign item_in.ready = !s1_valid_reg || out_load;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item_in.ready)
        begin
            s1_valid_reg <= item_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_in.valid && item_in.ready)
        begin
            s1_cmd_reg    <= item_in.cmd;
            s1_levels_reg <= item_in.key_levels;
        end
    end

    // Millisecond clock
    assign time_tick = time_now_reg + {24'd0, cfg_reg.tick_step_ms};
    assign time_key  = s1_cmd_reg ? time_now_reg : time_tick;
    assign tick_en   = s1_advance && !s1_cmd_reg;
    assign wake_en   = s1_advance && s1_cmd_reg && cfg_reg.low_power_enable;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_now_reg <= '0;
        end
        else if (tick_en)
        begin
            time_now_reg <= time_tick;
        end
    end

    // Per-key state machines
    for (genvar g = 0; g < NUM_KEYS; g++)
    begin : g_key
        logic key_level;

        if (g < MASK_W)
        begin : g_lvl
            assign key_level = s1_levels_reg[g];
        end
        else
        begin : g_nolvl
            assign key_level = 1'b0;
        end

        bced_key u_key (
            .clk     (clk),
            .rst_n   (rst_n),
            .tick_en (tick_en),
            .wake_en (wake_en),
            .level   (key_level),
            .t_now   (time_key),
            .cfg     (cfg_reg),
            .evt     (evt[g])
        );

        assign recent_vec[g] = evt[g].recent;
    end

    // Event masks; keys beyond the mask width only feed the idle check
    for (genvar m = 0; m < MASK_W; m++)
    begin : g_mask
        if (m < NUM_KEYS)
        begin : g_used
            assign lp_mask[m] = evt[m].hold_fire;
            assign sc_mask[m] = evt[m].tap_fire;
            assign dc_mask[m] = evt[m].dtap_fire;
        end
        else
        begin : g_unused
            assign lp_mask[m] = 1'b0;
            assign sc_mask[m] = 1'b0;
            assign dc_mask[m] = 1'b0;
        end
    end

    assign stop_flag = cfg_reg.low_power_enable && !(|recent_vec);

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            if (s1_cmd_reg)
            begin
                out_lp_reg   <= '0;
                out_sc_reg   <= '0;
                out_dc_reg   <= '0;
                out_stop_reg <= 1'b0;
            end
            else
            begin
                out_lp_reg   <= lp_mask;
                out_sc_reg   <= sc_mask;
                out_dc_reg   <= dc_mask;
                out_stop_reg <= stop_flag;
            end
        end
    end

    assign result_out.valid             = out_valid_reg;
    assign result_out.long_press_mask   = out_lp_reg;
    assign result_out.single_click_mask = out_sc_reg;
    assign result_out.double_click_mask = out_dc_reg;
    assign result_out.scan_stop         = out_stop_reg;

endmodule

### dv/tb_button_click_event_detector_top.sv
module tb_button_click_event_detector_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bced_pkg::*;

    localparam logic       CMD_SCAN   = 1'b0;
    localparam logic       CMD_WAKE   = 1'b1;
    localparam logic [1:0] MODE_ALIAS = 2'd3;   // decodes like MODE_ALL
    localparam int         KEYS       = 8;
    localparam int         LIMIT      = 500000;

    // One result beat: event masks and the scan stop flag
    typedef struct packed {
        logic [7:0] long_press_mask;
        logic [7:0] single_click_mask;
        logic [7:0] double_click_mask;
        logic       scan_stop;
    } click_events_t;

    // Click predictor plus store of expected result beats
    class click_scoreboard;
        cfg_t          regs;
        time_t         now_ms;
        key_state_t    st [KEYS];
        time_t         press_at [KEYS];
        time_t         release_at [KEYS];
        time_t         active_at [KEYS];
        click_events_t pending_events [$];
        int            mismatches;

        function new();
            int k;
            regs       = CFG_RESET;
            now_ms     = '0;
            mismatches = 0;
            for (k = 0; k < KEYS; k++)
            begin
                st[k]         = ST_IDLE;
                press_at[k]   = '0;
                release_at[k] = '0;
                active_at[k]  = '0;
            end
        endfunction

        function void write_reg(reg_index_t idx, logic [15:0] data);
            case (idx)
                REG_FEATURE_MODE:  regs.feature_mode           = data[1:0];
                REG_TICK_STEP:     regs.tick_step_ms           = data[7:0];
                REG_LONG_PRESS:    regs.long_press_ms          = data;
                REG_DOUBLE_WINDOW: regs.double_click_window_ms = data;
                REG_IDLE_TIMEOUT:  regs.idle_timeout_ms        = data;
                REG_LOW_POWER:     regs.low_power_enable       = data[0];
                default: ;
            endcase
        endfunction

        // Step every key machine for one accepted scan beat; a wake beat only refreshes stamps under low power
        function void note_input(logic cmd, logic [7:0] levels);
            click_events_t ev;
            bit            has_long;
            bit            has_double;
            bit            all_quiet;
            int            k;
            ev         = '0;
            has_long   = (regs.feature_mode != MODE_SINGLE);
            has_double = (regs.feature_mode >= MODE_ALL);
            if (cmd == CMD_WAKE)
            begin
                if (regs.low_power_enable)
                    for (k = 0; k < KEYS; k++)
                        active_at[k] = now_ms;
            end
            else
            begin
                now_ms    = now_ms + time_t'(regs.tick_step_ms);
                all_quiet = 1'b1;
                for (k = 0; k < KEYS; k++)
                begin
                    case (st[k])
                        ST_IDLE:
                            if (levels[k])
                            begin
                                st[k] = ST_PRESSED;
                                if (has_long)
                                    press_at[k] = now_ms;
                                if (regs.low_power_enable)
                                    active_at[k] = now_ms;
                            end
                        ST_PRESSED:
                            if (!levels[k])
                                st[k] = ST_RELEASED;
                            else if (has_long &&
                                     time_t'(now_ms - press_at[k]) >= regs.long_press_ms)
                            begin
                                st[k] = ST_LONG;
                                ev.long_press_mask[k] = 1'b1;
                            end
                        ST_RELEASED:
                            if (!has_double)
                            begin
                                st[k] = ST_IDLE;
                                ev.single_click_mask[k] = 1'b1;
                            end
                            else
                            begin
                                // second release inside the window is a double
                                if (time_t'(now_ms - release_at[k]) <=
                                    regs.double_click_window_ms)
                                begin
                                    st[k] = ST_DOUBLE;
                                    ev.double_click_mask[k] = 1'b1;
                                end
                                else
                                begin
                                    st[k] = ST_IDLE;
                                    ev.single_click_mask[k] = 1'b1;
                                end
                                release_at[k] = now_ms;
                            end
                        ST_LONG:
                            if (!has_long || !levels[k])
                                st[k] = ST_IDLE;
                        default:
                            st[k] = ST_IDLE;
                    endcase
                    if (time_t'(now_ms - active_at[k]) <= regs.idle_timeout_ms)
                        all_quiet = 1'b0;
                end
                ev.scan_stop = regs.low_power_enable && all_quiet;
            end
            pending_events.push_back(ev);
        endfunction

        function void check_result(logic [7:0] lp, logic [7:0] sc, logic [7:0] dc,
                                   logic stop);
            click_events_t want;
            if (pending_events.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result beat with none pending: long %h single %h double %h stop %b",
                             $realtime, lp, sc, dc, stop);
                return;
            end
            want = pending_events.pop_front();
            if (want.long_press_mask !== lp || want.single_click_mask !== sc ||
                want.double_click_mask !== dc || want.scan_stop !== stop)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: exp long %h single %h double %h stop %b, got %h %h %h %b",
                             $realtime, want.long_press_mask, want.single_click_mask,
                             want.double_click_mask, want.scan_stop, lp, sc, dc, stop);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   quiet = 1'b0;     // no idling on either side
    int   stall_left = 0;
    int   cycles = 0;

    click_scoreboard book = new();

    bced_in_if  item_if();
    bced_out_if res_if();
    bced_cfg_if cfg_if();

    button_click_event_detector_top DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_if),
        .result_out (res_if),
        .cfg_wr     (cfg_if)
    );

    always #6 clk = ~clk;

    // Result side back pressure in bursts
    always @(posedge clk)
    begin
        if (!quiet && stall_left == 0 && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 9);
        if (stall_left > 0)
        begin
            res_if.ready <= 1'b0;
            stall_left--;
        end
        else
            res_if.ready <= 1'b1;
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
            book.check_result(res_if.long_press_mask, res_if.single_click_mask,
                              res_if.double_click_mask, res_if.scan_stop);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // One input beat, with an optional gap in front
    task automatic send_beat(logic cmd, logic [7:0] levels);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        item_if.valid      <= 1'b1;
        item_if.cmd        <= cmd;
        item_if.key_levels <= levels;
        do @(posedge clk); while (!item_if.ready);
        book.note_input(cmd, levels);
    endtask

    // Let the pipe drain, then write all six registers
    task automatic configure(cfg_t c);
        logic [15:0] vals [6];
        int          r;
        vals[0] = 16'(c.feature_mode);
        vals[1] = 16'(c.tick_step_ms);
        vals[2] = c.long_press_ms;
        vals[3] = c.double_click_window_ms;
        vals[4] = c.idle_timeout_ms;
        vals[5] = 16'(c.low_power_enable);
        item_if.valid <= 1'b0;
        while (book.pending_events.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        for (r = 0; r < 6; r++)
        begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= reg_index_t'(r);
            cfg_if.data  <= vals[r];
            do @(posedge clk); while (!cfg_if.ready);
            book.write_reg(reg_index_t'(r), vals[r]);
        end
        cfg_if.valid <= 1'b0;
    endtask

    // Time value: often an extreme, otherwise a small span
    function automatic logic [15:0] pick_ms(int span);
        case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, span));
        endcase
    endfunction

    initial
    begin
        cfg_t       phase_cfg;
        logic [7:0] held;
        int         flip_div;
        int         p;
        int         k;

        clk                = 1'b0;
        rst_n              = 1'b0;
        item_if.valid      = 1'b0;
        item_if.cmd        = CMD_SCAN;
        item_if.key_levels = '0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = REG_FEATURE_MODE;
        cfg_if.data        = '0;
        res_if.ready       = 1'b0;
        held               = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: all keys click at once; first release right after
        // time zero lands inside the window and reports a double
        send_beat(CMD_SCAN, 8'h00);
        send_beat(CMD_SCAN, 8'hFF);
        send_beat(CMD_SCAN, 8'h00);
        send_beat(CMD_SCAN, 8'h00);
        send_beat(CMD_SCAN, 8'h00);
        send_beat(CMD_WAKE, 8'hFF);     // low power off: no effect

        // Single plus long, zero thresholds, low power on
        configure('{feature_mode: MODE_SINGLE_LONG, tick_step_ms: 8'd255,
                    long_press_ms: 16'd0, double_click_window_ms: 16'd0,
                    idle_timeout_ms: 16'd0, low_power_enable: 1'b1});
        send_beat(CMD_SCAN, 8'h01);
        send_beat(CMD_SCAN, 8'h01);
        send_beat(CMD_WAKE, 8'h00);
        send_beat(CMD_SCAN, 8'h00);
        send_beat(CMD_SCAN, 8'h02);
        send_beat(CMD_SCAN, 8'h00);
        send_beat(CMD_SCAN, 8'h00);
        send_beat(CMD_SCAN, 8'h80);
        send_beat(CMD_SCAN, 8'h80);     // key 7 parked in long press

        // Single click only: the parked long press drops to idle silently
        configure('{feature_mode: MODE_SINGLE, tick_step_ms: 8'd1,
                    long_press_ms: 16'hFFFF, double_click_window_ms: 16'hFFFF,
                    idle_timeout_ms: 16'hFFFF, low_power_enable: 1'b1});
        send_beat(CMD_SCAN, 8'h80);
        send_beat(CMD_SCAN, 8'h55);
        send_beat(CMD_SCAN, 8'h00);
        send_beat(CMD_SCAN, 8'h00);

        // Mode code three runs the full rule set; park keys in double click
        configure('{feature_mode: MODE_ALIAS, tick_step_ms: 8'd1,
                    long_press_ms: 16'hFFFF, double_click_window_ms: 16'hFFFF,
                    idle_timeout_ms: 16'hFFFF, low_power_enable: 1'b1});
        send_beat(CMD_SCAN, 8'hAA);
        send_beat(CMD_SCAN, 8'h00);
        send_beat(CMD_SCAN, 8'h00);

        // Double click state outside its mode returns to idle silently
        configure('{feature_mode: MODE_SINGLE_LONG, tick_step_ms: 8'd1,
                    long_press_ms: 16'hFFFF, double_click_window_ms: 16'hFFFF,
                    idle_timeout_ms: 16'hFFFF, low_power_enable: 1'b1});
        send_beat(CMD_SCAN, 8'h00);
        send_beat(CMD_WAKE, 8'h00);

        // Random phases: keys held for random stretches, some wake beats
        for (p = 0; p < 8; p++)
        begin
            phase_cfg.feature_mode           = 2'($urandom_range(0, 3));
            phase_cfg.tick_step_ms           = (p == 0) ? 8'd1 :
                                               (p == 1) ? 8'd255 :
                                               8'($urandom_range(1, 64));
            phase_cfg.long_press_ms          = pick_ms(400);
            phase_cfg.double_click_window_ms = pick_ms(200);
            phase_cfg.idle_timeout_ms        = pick_ms(300);
            phase_cfg.low_power_enable       = (p % 2 == 0) ? 1'b1 : 1'($urandom_range(0, 1));
            configure(phase_cfg);
            quiet    = (p == 7);
            flip_div = 1 << $urandom_range(1, 4);
            repeat (105)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_beat(CMD_WAKE, 8'($urandom_range(0, 255)));
                else
                begin
                    for (k = 0; k < KEYS; k++)
                        if ($urandom_range(0, flip_div - 1) == 0)
                            held[k] = ~held[k];
                    send_beat(CMD_SCAN, held);
                end
            end
        end

        // Drain and report
        item_if.valid <= 1'b0;
        while (book.pending_events.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (book.mismatches == 0 && book.pending_events.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
